// ===== rtl/cart_pkg.sv =====
`default_nettype none
package cart_pkg;

  localparam int SLOTS_DEF = 8;

  localparam int TARGET_W = 8;
  localparam int CODE_W   = 8;
  localparam int TIME_W   = 32;
  localparam int SEQ_W    = 16;
  localparam int RETRY_W  = 4;
  localparam int KIND_W   = 3;
  localparam int SLOTF_W  = 3;
  localparam int TOUT_W   = 16;

  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 72;

  localparam logic [15:0] TIMEOUT_RST = 16'd500;
  localparam logic [3:0]  MAXRET_RST  = 4'd3;
  localparam logic [7:0]  HBCODE_RST  = 8'd0;

  // input actions
  localparam logic [1:0] ACT_ISSUE = 2'd0;
  localparam logic [1:0] ACT_ACK   = 2'd1;
  localparam logic [1:0] ACT_TICK  = 2'd2;

  // register indexes
  localparam logic [1:0] REG_TIMEOUT = 2'd0;
  localparam logic [1:0] REG_MAXRET  = 2'd1;
  localparam logic [1:0] REG_HBCODE  = 2'd2;

  // result kinds
  localparam logic [2:0] KIND_QUEUED    = 3'd0;
  localparam logic [2:0] KIND_HEARTBEAT = 3'd1;
  localparam logic [2:0] KIND_FULL      = 3'd2;
  localparam logic [2:0] KIND_ACKED     = 3'd3;
  localparam logic [2:0] KIND_UNMATCHED = 3'd4;
  localparam logic [2:0] KIND_RETRY     = 3'd5;
  localparam logic [2:0] KIND_GAVE_UP   = 3'd6;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_EVAL,
    ST_FLUSH
  } state_t;

  typedef struct packed {
    logic [TARGET_W-1:0] target;
    logic [CODE_W-1:0]   code;
    logic [TIME_W-1:0]   cmd_time;
    logic [SEQ_W-1:0]    seq_num;
    logic [TIME_W-1:0]   sent_at;
    logic [RETRY_W-1:0]  retries;
  } slot_entry_t;

  typedef struct packed {
    logic [KIND_W-1:0]   kind;
    logic [SLOTF_W-1:0]  slot;
    logic [TARGET_W-1:0] target;
    logic [CODE_W-1:0]   code;
    logic [TIME_W-1:0]   cmd_time;
    logic [SEQ_W-1:0]    seq_num;
    logic [RETRY_W-1:0]  attempt;
  } result_t;

endpackage
`default_nettype wire

// ===== rtl/cart_slot_ram.sv =====
`default_nettype none
module cart_slot_ram #(
  parameter int DEPTH  = cart_pkg::SLOTS_DEF,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire                      clk,
  input  wire                      we,
  input  wire [ADDR_W-1:0]         waddr,
  input  cart_pkg::slot_entry_t    wdata,
  input  wire                      re,
  input  wire [ADDR_W-1:0]         raddr,
  output cart_pkg::slot_entry_t    rdata
);
  import cart_pkg::*;

  slot_entry_t mem [DEPTH];
  slot_entry_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

// ===== rtl/command_ack_retry_tracker.sv =====
`default_nettype none
// channel  | direction | handshake             | payload
// in_      | slave     | in_tvalid/in_tready   | tuser action, tdata target/code/time
// out_     | master    | out_tvalid/out_tready | tuser kind, tdata result, tlast
// cfg_     | apb slave | psel/penable, pready  | timeout, retry limit, heartbeat code
//
// an issue request is accepted, then its result is loaded; nothing is read back
// an ack or tick request walks the slot memory one slot at a time, read then eval,
// through its single read port; an ack stops at its first match
// one request at a time; a tick result waits in a hold stage until the next due
// slot or the end of the scan sets tlast, and the scan stalls on a full output
// reset (synchronous, rst_n low) frees all slots and clears both counters
module command_ack_retry_tracker #(
  parameter int SLOTS = cart_pkg::SLOTS_DEF
) (
  input  wire        clk,
  input  wire        rst_n,
  // input requests
  input  wire        in_tvalid,
  output logic       in_tready,
  input  wire [47:0] in_tdata,   // target_id[7:0], command_code[15:8], command_time[47:16]
  input  wire [1:0]  in_tuser,   // action[1:0]
  // results
  output logic       out_tvalid,
  input  wire        out_tready,
  output logic [71:0] out_tdata, // slot[2:0], out_target[10:3], out_code[18:11],
                                 // out_time[50:19], sequence_number[66:51],
                                 // attempt[70:67], zero[71]
  output logic [2:0] out_tuser,  // kind[2:0]
  output logic       out_tlast,
  // configuration
  input  wire        cfg_psel,
  input  wire        cfg_penable,
  input  wire        cfg_pwrite,
  input  wire [3:0]  cfg_paddr,
  input  wire [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic       cfg_pready
);
  import cart_pkg::*;

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  // configuration registers
  logic [TOUT_W-1:0]  timeout_r;
  logic [RETRY_W-1:0] maxret_r;
  logic [CODE_W-1:0]  hbcode_r;

  // control state
  state_t             state_r, state_nxt;
  logic [SLOTS-1:0]   pending_r, pending_nxt;
  logic [TIME_W-1:0]  now_r, now_nxt;
  logic [SEQ_W-1:0]   seq_r, seq_nxt;
  logic [IDX_W-1:0]   idx_r, idx_nxt;
  logic               hold_valid_r, hold_valid_nxt;
  logic               out_valid_r, out_valid_nxt;

  // payload registers
  logic [1:0]          act_r, act_nxt;
  logic [TARGET_W-1:0] tgt_r, tgt_nxt;
  logic [CODE_W-1:0]   code_r, code_nxt;
  logic [TIME_W-1:0]   time_r, time_nxt;
  result_t             hold_r, hold_nxt;
  result_t             out_res_r, out_res_nxt;
  logic                out_last_r, out_last_nxt;

  // slot memory port
  logic        mem_we, mem_re;
  logic [IDX_W-1:0] mem_waddr;
  slot_entry_t mem_wdata, mem_rdata;

  // request fields
  logic [TARGET_W-1:0] in_tgt;
  logic [CODE_W-1:0]   in_code;
  logic [TIME_W-1:0]   in_time;
  logic                in_acc;

  // scan conditions
  logic             free_found;
  logic [IDX_W-1:0] free_idx;
  logic [IDX_W+2:0] free_ext, idx_ext;
  logic             is_last, can_emit, hit, due, stall, give_up;
  logic [TIME_W-1:0] age;
  logic [RETRY_W-1:0] retry_inc;
  logic             push;

  assign in_tgt  = in_tdata[7:0];
  assign in_code = in_tdata[15:8];
  assign in_time = in_tdata[47:16];
  assign in_tready = (state_r == ST_IDLE);
  assign in_acc  = in_tvalid && in_tready;

  assign can_emit = !out_valid_r || out_tready;
  assign is_last  = (idx_r == IDX_W'(SLOTS - 1));
  assign free_ext = {3'b000, free_idx};
  assign idx_ext  = {3'b000, idx_r};

  // lowest free slot
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!pending_r[i]) begin
        free_found = 1'b1;
        free_idx   = IDX_W'(i);
      end
    end
  end

  // checks on the entry read back from memory
  assign hit = pending_r[idx_r] && (mem_rdata.target == tgt_r) &&
               (mem_rdata.code == code_r) && (mem_rdata.cmd_time == time_r);
  assign age       = now_r - mem_rdata.sent_at;
  assign due       = pending_r[idx_r] && (age >= {16'd0, timeout_r});
  assign give_up   = (mem_rdata.retries >= maxret_r);
  assign retry_inc = mem_rdata.retries + 4'd1;
  // a new tick result needs the hold stage, whose old result needs the output
  assign stall     = due && hold_valid_r && !can_emit;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          case (in_tuser)
            ACT_ISSUE:         state_nxt = ST_FLUSH;
            ACT_ACK, ACT_TICK: state_nxt = ST_READ;
            default:           state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_READ: state_nxt = ST_EVAL;
      ST_EVAL: begin
        if (act_r == ACT_ACK) begin
          if (hit || is_last) state_nxt = ST_FLUSH;
          else                state_nxt = ST_READ;
        end else if (!stall) begin
          state_nxt = is_last ? ST_FLUSH : ST_READ;
        end
      end
      ST_FLUSH: begin
        if (!hold_valid_r || can_emit) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    pending_nxt    = pending_r;
    now_nxt        = now_r;
    seq_nxt        = seq_r;
    idx_nxt        = idx_r;
    hold_valid_nxt = hold_valid_r;
    hold_nxt       = hold_r;
    act_nxt        = act_r;
    tgt_nxt        = tgt_r;
    code_nxt       = code_r;
    time_nxt       = time_r;
    push           = 1'b0;
    out_last_nxt   = out_last_r;
    mem_we         = 1'b0;
    mem_re         = 1'b0;
    mem_waddr      = idx_r;
    mem_wdata      = mem_rdata;

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          act_nxt  = in_tuser;
          tgt_nxt  = in_tgt;
          code_nxt = in_code;
          time_nxt = in_time;
          idx_nxt  = '0;
          case (in_tuser)
            ACT_ISSUE: begin
              seq_nxt         = seq_r + 16'd1;
              hold_valid_nxt  = 1'b1;
              hold_nxt.slot   = '0;
              hold_nxt.target = in_tgt;
              hold_nxt.code   = in_code;
              hold_nxt.cmd_time = in_time;
              hold_nxt.seq_num  = seq_nxt;
              hold_nxt.attempt  = '0;
              if (in_code == hbcode_r) begin
                hold_nxt.kind = KIND_HEARTBEAT;
              end else if (!free_found) begin
                hold_nxt.kind = KIND_FULL;
              end else begin
                hold_nxt.kind = KIND_QUEUED;
                hold_nxt.slot = free_ext[2:0];
                pending_nxt[free_idx] = 1'b1;
                mem_we    = 1'b1;
                mem_waddr = free_idx;
                mem_wdata = '{target: in_tgt, code: in_code, cmd_time: in_time,
                              seq_num: seq_nxt, sent_at: now_r, retries: '0};
              end
            end
            ACT_TICK: now_nxt = now_r + 32'd1;
            default: ;
          endcase
        end
      end
      ST_READ: mem_re = 1'b1;
      ST_EVAL: begin
        if (act_r == ACT_ACK) begin
          if (hit) begin
            pending_nxt[idx_r] = 1'b0;
            hold_valid_nxt = 1'b1;
            hold_nxt = '{kind: KIND_ACKED, slot: idx_ext[2:0],
                         target: mem_rdata.target, code: mem_rdata.code,
                         cmd_time: mem_rdata.cmd_time, seq_num: mem_rdata.seq_num,
                         attempt: mem_rdata.retries};
          end else if (is_last) begin
            hold_valid_nxt = 1'b1;
            hold_nxt = '{kind: KIND_UNMATCHED, slot: '0, target: tgt_r,
                         code: code_r, cmd_time: time_r, seq_num: '0, attempt: '0};
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end else if (!stall) begin
          if (due) begin
            if (hold_valid_r) begin
              push         = 1'b1;
              out_last_nxt = 1'b0;
            end
            hold_valid_nxt = 1'b1;
            hold_nxt.slot     = idx_ext[2:0];
            hold_nxt.target   = mem_rdata.target;
            hold_nxt.code     = mem_rdata.code;
            hold_nxt.cmd_time = mem_rdata.cmd_time;
            hold_nxt.seq_num  = mem_rdata.seq_num;
            if (give_up) begin
              pending_nxt[idx_r] = 1'b0;
              hold_nxt.kind    = KIND_GAVE_UP;
              hold_nxt.attempt = mem_rdata.retries;
            end else begin
              hold_nxt.kind     = KIND_RETRY;
              hold_nxt.attempt  = retry_inc;
              mem_we            = 1'b1;
              mem_wdata.retries = retry_inc;
              mem_wdata.sent_at = now_r;
            end
          end
          if (!is_last) idx_nxt = idx_r + 1'b1;
        end
      end
      ST_FLUSH: begin
        if (hold_valid_r && can_emit) begin
          push           = 1'b1;
          out_last_nxt   = 1'b1;
          hold_valid_nxt = 1'b0;
        end
      end
      default: ;
    endcase
  end

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;
    if (push) begin
      out_valid_nxt = 1'b1;
      out_res_nxt   = hold_r;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      pending_r    <= '0;
      now_r        <= '0;
      seq_r        <= '0;
      idx_r        <= '0;
      hold_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      pending_r    <= pending_nxt;
      now_r        <= now_nxt;
      seq_r        <= seq_nxt;
      idx_r        <= idx_nxt;
      hold_valid_r <= hold_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_r      <= act_nxt;
    tgt_r      <= tgt_nxt;
    code_r     <= code_nxt;
    time_r     <= time_nxt;
    hold_r     <= hold_nxt;
    out_res_r  <= out_res_nxt;
    out_last_r <= out_last_nxt;
  end

  cart_slot_ram #(
    .DEPTH  (SLOTS),
    .ADDR_W (IDX_W)
  ) u_slot_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (idx_r),
    .rdata (mem_rdata)
  );

  // configuration port, writes complete in the access phase
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= TIMEOUT_RST;
      maxret_r  <= MAXRET_RST;
      hbcode_r  <= HBCODE_RST;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
      case (cfg_paddr[3:2])
        REG_TIMEOUT: timeout_r <= cfg_pwdata[15:0];
        REG_MAXRET:  maxret_r  <= cfg_pwdata[3:0];
        REG_HBCODE:  hbcode_r  <= cfg_pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[3:2])
      REG_TIMEOUT: cfg_prdata = {16'd0, timeout_r};
      REG_MAXRET:  cfg_prdata = {28'd0, maxret_r};
      REG_HBCODE:  cfg_prdata = {24'd0, hbcode_r};
      default:     cfg_prdata = 32'd0;
    endcase
  end

  // result packing
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.kind;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {1'b0, out_res_r.attempt, out_res_r.seq_num, out_res_r.cmd_time,
                       out_res_r.code, out_res_r.target, out_res_r.slot};

endmodule
`default_nettype wire
